// File: rtl/mkt_pkg.sv
// types, constants and code tables shared by the morse keyer files
package mkt_pkg;

    // command codes of an input item
    localparam logic CMD_CHAR = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // character codes
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_A     = 8'h41;
    localparam logic [7:0] CHAR_Z     = 8'h5A;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;

    localparam logic [15:0] TPU_RESET = 16'd100;

    // unit counts of the phases
    localparam logic [2:0] DOT_UNITS   = 3'd1;
    localparam logic [2:0] DASH_UNITS  = 3'd3;
    localparam logic [2:0] SPACE_UNITS = 3'd1;
    localparam logic [2:0] GAP_UNITS   = 3'd2;
    localparam logic [2:0] WORD_UNITS  = 3'd6;

    localparam int CODE_W = 5;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_ON   = 4'b0010,
        PH_OFF  = 4'b0100,
        PH_GAP  = 4'b1000
    } phase_t;

    typedef struct packed {
        logic       command;
        logic [7:0] char_code;
    } in_item_t;

    typedef struct packed {
        logic key_level;
        logic busy_res;
        logic rejected;
    } out_item_t;

    // element count and pattern, bit 0 = first element, 1 = dash
    typedef struct packed {
        logic [2:0]        len;
        logic [CODE_W-1:0] pat;
    } code_t;

    typedef struct packed {
        logic  hit;
        code_t code;
    } lookup_t;

    localparam code_t LETTER_TABLE [26] = '{
        8'b010_00010, // a
        8'b100_00001, // b
        8'b100_00101, // c
        8'b011_00001, // d
        8'b001_00000, // e
        8'b100_00100, // f
        8'b011_00011, // g
        8'b100_00000, // h
        8'b010_00000, // i
        8'b100_01110, // j
        8'b011_00101, // k
        8'b100_00010, // l
        8'b010_00011, // m
        8'b010_00001, // n
        8'b011_00111, // o
        8'b100_00110, // p
        8'b100_01011, // q
        8'b011_00010, // r
        8'b011_00000, // s
        8'b001_00001, // t
        8'b011_00100, // u
        8'b100_01000, // v
        8'b011_00110, // w
        8'b100_01001, // x
        8'b100_01101, // y
        8'b100_00011  // z
    };

    localparam code_t DIGIT_TABLE [10] = '{
        8'b101_11111,
        8'b101_11110,
        8'b101_11100,
        8'b101_11000,
        8'b101_10000,
        8'b101_00000,
        8'b101_00001,
        8'b101_00011,
        8'b101_00111,
        8'b101_01111
    };

    function automatic lookup_t morse_lookup(input logic [7:0] c);
        lookup_t    res;
        logic [7:0] ofs_l;
        logic [7:0] ofs_d;
        res   = '0;
        ofs_l = c - CHAR_A;
        ofs_d = c - CHAR_0;
        if (c >= CHAR_A && c <= CHAR_Z)
        begin
            res.hit  = 1'b1;
            res.code = LETTER_TABLE[ofs_l[4:0]];
        end
        else if (c >= CHAR_0 && c <= CHAR_9)
        begin
            res.hit  = 1'b1;
            res.code = DIGIT_TABLE[ofs_d[3:0]];
        end
        return res;
    endfunction

endpackage

// File: rtl/mkt_keyer_core.sv
// keyer state registers and the per-item state update
module mkt_keyer_core #(
    parameter int MAX_ELEMENTS = 5
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  mkt_pkg::in_item_t item,
    input  logic [15:0]       ticks_per_unit,
    output mkt_pkg::out_item_t result
);
    import mkt_pkg::*;

    localparam int CNT_W = $clog2(MAX_ELEMENTS);

    phase_t                  phase_reg, phase_next;
    logic [MAX_ELEMENTS-1:0] pattern_reg, pattern_next;
    logic [CNT_W-1:0]        elem_left_reg, elem_left_next;
    logic [2:0]              units_reg, units_next;
    logic [15:0]             ticks_reg, ticks_next;

    always_comb
    begin
        logic [15:0]             unit_len;
        logic [15:0]             t1;
        logic [2:0]              u1;
        logic                    rej;
        lookup_t                 lk;
        logic [MAX_ELEMENTS-1:0] pat;
        unit_len       = (ticks_per_unit == 16'd0) ? 16'd1 : ticks_per_unit;
        phase_next     = phase_reg;
        pattern_next   = pattern_reg;
        elem_left_next = elem_left_reg;
        units_next     = units_reg;
        ticks_next     = ticks_reg;
        rej            = 1'b0;
        lk             = morse_lookup(item.char_code);
        pat            = MAX_ELEMENTS'(lk.code.pat);
        t1             = (ticks_reg != 16'd0) ? ticks_reg - 16'd1 : 16'd0;
        u1             = (units_reg != 3'd0) ? units_reg - 3'd1 : 3'd0;

        if (item.command == CMD_TICK)
        begin
            if (phase_reg != PH_IDLE)
            begin
                if (t1 != 16'd0)
                    ticks_next = t1;
                else if (u1 != 3'd0)
                begin
                    units_next = u1;
                    ticks_next = unit_len;
                end
                else
                begin
                    case (phase_reg)
                        PH_ON:
                        begin
                            phase_next = PH_OFF;
                            units_next = SPACE_UNITS;
                            ticks_next = unit_len;
                        end
                        PH_OFF:
                        begin
                            ticks_next = unit_len;
                            if (elem_left_reg != '0)
                            begin
                                elem_left_next = elem_left_reg - CNT_W'(1);
                                phase_next     = PH_ON;
                                units_next     = pattern_reg[0] ? DASH_UNITS : DOT_UNITS;
                                pattern_next   = pattern_reg >> 1;
                            end
                            else
                            begin
                                phase_next = PH_GAP;
                                units_next = GAP_UNITS;
                            end
                        end
                        default:
                        begin
                            phase_next     = PH_IDLE;
                            units_next     = 3'd0;
                            ticks_next     = 16'd0;
                            pattern_next   = '0;
                            elem_left_next = '0;
                        end
                    endcase
                end
            end
        end
        else if (phase_reg != PH_IDLE)
            rej = 1'b1;
        else
        begin
            ticks_next = unit_len;
            if (item.char_code == CHAR_SPACE)
            begin
                phase_next = PH_GAP;
                units_next = WORD_UNITS;
            end
            else if (!lk.hit)
            begin
                phase_next = PH_GAP;
                units_next = GAP_UNITS;
            end
            else
            begin
                // first element starts in this same item
                phase_next     = PH_ON;
                units_next     = pat[0] ? DASH_UNITS : DOT_UNITS;
                pattern_next   = pat >> 1;
                elem_left_next = CNT_W'(lk.code.len - 3'd1);
            end
        end

        result.key_level = (phase_next == PH_ON);
        result.busy_res  = (phase_next != PH_IDLE);
        result.rejected  = rej;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            pattern_reg   <= '0;
            elem_left_reg <= '0;
            units_reg     <= 3'd0;
            ticks_reg     <= 16'd0;
        end
        else if (fire)
        begin
            phase_reg     <= phase_next;
            pattern_reg   <= pattern_next;
            elem_left_reg <= elem_left_next;
            units_reg     <= units_next;
            ticks_reg     <= ticks_next;
        end
    end

    // a dropped character leaves the timing untouched
    a_reject_holds: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.command == CMD_CHAR && phase_reg != PH_IDLE
        |=> $stable(phase_reg) && $stable(ticks_reg) && $stable(units_reg))
        else $error("rejected character changed state");

    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE
        |-> ticks_reg == 16'd0 && units_reg == 3'd0 && elem_left_reg == '0)
        else $error("idle with counters not cleared");

    a_busy_counts: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != PH_IDLE |-> units_reg != 3'd0 && ticks_reg != 16'd0)
        else $error("busy phase with exhausted counters");

    a_no_fire_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(phase_reg) && $stable(ticks_reg))
        else $error("state moved without an item");

endmodule

// File: rtl/morse_keyer_transmitter.sv
// top level of the morse keyer: input register, keyer core, result register
//
// usage
// - input channel in_valid / in_stall / in_data: each item is either a
//   character (command 0, ascii in char_code) or one time tick (command 1)
// - output channel out_valid / out_stall / out_data: exactly one result item
//   per input item, in order: key line level, busy flag, rejected flag
// - cfg_wr_en / cfg_wr_data write ticks_per_unit; write only while idle,
//   a value of zero counts as one tick per unit
// - an item accepted by the input stage is registered there, and its result
//   is loaded into the output register once that register is free or draining;
//   out_valid rises with that load
// - throughput: one item per cycle while the receiver does not stall, set by
//   the single-pass state update between the input and result registers
// - the input stage takes a new item while a result waits, as long as the
//   result register is free or is being drained in the same cycle
// - when the receiver stalls, the result holds and the input register
//   fills; in_stall then rises until the result is taken
// - reset clears both stages, puts the keyer in idle with the line off,
//   and loads ticks_per_unit with 100
module morse_keyer_transmitter #(
    parameter int MAX_ELEMENTS = 5
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  mkt_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output mkt_pkg::out_item_t out_data,
    input  logic               cfg_wr_en,
    input  logic [15:0]        cfg_wr_data
);
    import mkt_pkg::*;

    // input stage
    logic      s1_valid_reg;
    in_item_t  s1_item_reg;
    // result stage
    logic      out_valid_reg;
    out_item_t out_item_reg;
    // unit length register
    logic [15:0] tpu_reg;

    logic      advance;
    logic      in_take;
    out_item_t core_result;

    // an item moves into the result register when it is free or draining
    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tpu_reg <= TPU_RESET;
        else if (cfg_wr_en)
            tpu_reg <= cfg_wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_take)
            s1_valid_reg <= 1'b1;
        else if (advance)
            s1_valid_reg <= 1'b0;
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
            s1_item_reg <= in_data;
    end

    mkt_keyer_core #(
        .MAX_ELEMENTS(MAX_ELEMENTS)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (advance),
        .item           (s1_item_reg),
        .ticks_per_unit (tpu_reg),
        .result         (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_item_reg <= core_result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

endmodule
